### sv/u8d_pkg.sv
// shared types, constants and the lead byte decode function for the utf-8 decoder
// no dependencies; imported by u8d_core, u8d_fifo, utf8_byte_stream_decoder and the testbench
package u8d_pkg;

	// field widths
	localparam int BYTE_W   = 8;
	localparam int FOLLOW_W = 2;
	localparam int CP_W     = 21;
	localparam int COUNT_W  = 2;

	// packed stream widths, rounded up to whole bytes
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	// default depth of the result queue
	localparam int FIFO_DEPTH_DEF = 4;

	// code points and byte masks
	localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [BYTE_W-1:0] LEAD2_MASK     = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_CODE     = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK     = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_CODE     = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK     = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_CODE     = 8'hF0;
	localparam logic [BYTE_W-1:0] PAY2_MASK      = 8'h1F;
	localparam logic [BYTE_W-1:0] PAY3_MASK      = 8'h0F;
	localparam logic [BYTE_W-1:0] PAY4_MASK      = 8'h07;
	localparam logic [BYTE_W-1:0] CONT_MASK      = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_CODE      = 8'h80;
	localparam logic [BYTE_W-1:0] ASCII_LIMIT    = 8'h80;

	// number of results an input byte produces
	localparam logic [1:0] NRES_NONE = 2'd0;
	localparam logic [1:0] NRES_ONE  = 2'd1;
	localparam logic [1:0] NRES_TWO  = 2'd2;

	// one result item
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            bad;
		logic            fin;
	} res_t;

	// results of one input byte, handed from the decoder to the queue
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} res_pair_t;

	// outcome of decoding a byte as the first byte of a form
	typedef struct packed {
		logic               has_res;
		logic [CP_W-1:0]    cp;
		logic               bad;
		logic               open;
		logic [COUNT_W-1:0] need;
		logic [CP_W-1:0]    payload;
		logic               trunc;
		logic [COUNT_W-1:0] discard;
	} lead_t;

	function automatic lead_t decode_lead(input logic [BYTE_W-1:0] b,
		input logic [FOLLOW_W-1:0] follow);
		lead_t              l;
		logic [COUNT_W-1:0] need;
		logic [BYTE_W-1:0]  pay;
		logic               is_lead;
		l       = '0;
		need    = '0;
		pay     = '0;
		is_lead = 1'b1;
		if (b < ASCII_LIMIT) begin
			is_lead = 1'b0;
			l.has_res = 1'b1;
			l.cp      = CP_W'(b);
		end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			need = 2'd1;
			pay  = b & PAY2_MASK;
		end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			need = 2'd2;
			pay  = b & PAY3_MASK;
		end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
			need = 2'd3;
			pay  = b & PAY4_MASK;
		end else begin
			// stray continuation or an invalid lead
			is_lead = 1'b0;
			l.has_res = 1'b1;
			l.cp      = REPLACEMENT_CP;
			l.bad     = 1'b1;
		end
		if (is_lead) begin
			if (follow < need) begin
				// string ends before the form does
				l.has_res = 1'b1;
				l.cp      = REPLACEMENT_CP;
				l.bad     = 1'b1;
				l.trunc   = 1'b1;
				l.discard = follow;
			end else begin
				l.open    = 1'b1;
				l.need    = need;
				l.payload = CP_W'(pay);
			end
		end
		return l;
	endfunction

endpackage

### sv/utf8_byte_stream_decoder.sv
// top level of the utf-8 byte stream decoder: input stage, decoder and result queue
// depends on u8d_pkg, u8d_core and u8d_fifo
//
// Usage
//   Slave channel s_*: one byte of a utf-8 string per transaction, with the
//   count of bytes still following it in the string, saturated at 3.
//   Master channel m_*: decoded code points. m_tuser flags a replacement
//   (U+FFFD) for malformed input; m_tlast marks the last result caused by one
//   input byte. A byte gives zero, one or two results.
//   A byte passes the input register, its results are written into the result
//   queue, and from there they appear on m_*.
//   Throughput: one byte per cycle while results are taken as fast as they
//   come; the output side moves one result per cycle, so bytes that give two
//   results set the pace. The input register moves into the result queue only
//   while the queue holds at most DEPTH-2 entries.
//   When the receiver stalls, results collect in the queue and s_tready drops
//   once it is near full; nothing is lost.
//   Reset clears the open sequence, the drop count, the input stage and the
//   queue; the block is ready straight out of reset.
module utf8_byte_stream_decoder #(
	parameter int FIFO_DEPTH = u8d_pkg::FIFO_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [u8d_pkg::IN_TDATA_W-1:0]   s_tdata,  // data_byte, bytes_following, zero pad
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [u8d_pkg::OUT_TDATA_W-1:0]  m_tdata,  // code_point, zero pad
	output logic                             m_tuser,  // malformed
	output logic                             m_tlast   // final_of_run
);
	import u8d_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic [FOLLOW_W-1:0] follow_s1;
	logic                room;
	logic                fire;
	res_pair_t           res;
	res_t                head;

	// input stage moves on when the queue has room for two results
	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1   <= s_tdata[BYTE_W-1:0];
			follow_s1 <= s_tdata[BYTE_W+FOLLOW_W-1:BYTE_W];
		end
	end

	// sequence decoder
	u8d_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.data_byte       (byte_s1),
		.bytes_following (follow_s1),
		.res             (res)
	);

	// result queue
	u8d_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.pop       (m_tready),
		.room      (room),
		.not_empty (m_tvalid),
		.head      (head)
	);

	// output packing
	assign m_tdata = {{(OUT_TDATA_W-CP_W){1'b0}}, head.cp};
	assign m_tuser = head.bad;
	assign m_tlast = head.fin;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with an empty input stage");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(byte_s1) && $stable(follow_s1)))
		else $error("input stage lost a byte while blocked");

	a_valid_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tdata[CP_W-1:0] == REPLACEMENT_CP)
		else $error("malformed result without replacement code point");

endmodule

### sv/u8d_core.sv
// utf-8 sequence state and per-byte decode for the utf-8 decoder
// depends on u8d_pkg
module u8d_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [u8d_pkg::BYTE_W-1:0]    data_byte,
	input  logic [u8d_pkg::FOLLOW_W-1:0]  bytes_following,
	output u8d_pkg::res_pair_t            res
);
	import u8d_pkg::*;

	logic [COUNT_W-1:0] cont_q, cont_d;
	logic [CP_W-1:0]    part_q, part_d;
	logic [COUNT_W-1:0] disc_q, disc_d;
	lead_t              lead;
	logic [CP_W-1:0]    part_acc;

	assign lead     = decode_lead(data_byte, bytes_following);
	assign part_acc = {part_q[CP_W-7:0], data_byte[5:0]};

	// decode one byte against the open sequence
	always_comb begin
		cont_d = cont_q;
		part_d = part_q;
		disc_d = disc_q;
		res    = '0;
		if (fire) begin
			if (disc_q != '0) begin
				disc_d = disc_q - 2'd1;
			end else if (cont_q != '0) begin
				if ((data_byte & CONT_MASK) == CONT_CODE) begin
					cont_d = cont_q - 2'd1;
					if (cont_q == 2'd1) begin
						res.n  = NRES_ONE;
						res.r0 = '{cp: part_acc, bad: 1'b0, fin: 1'b1};
						part_d = '0;
					end else begin
						part_d = part_acc;
					end
				end else begin
					// bad continuation: replace, then decode the byte as a lead
					cont_d = '0;
					part_d = '0;
					res.r0 = '{cp: REPLACEMENT_CP, bad: 1'b1, fin: 1'b0};
					if (lead.has_res) begin
						res.n  = NRES_TWO;
						res.r1 = '{cp: lead.cp, bad: lead.bad, fin: 1'b1};
					end else begin
						res.n      = NRES_ONE;
						res.r0.fin = 1'b1;
					end
					if (lead.open) begin
						cont_d = lead.need;
						part_d = lead.payload;
					end
					if (lead.trunc) begin
						disc_d = lead.discard;
					end
				end
			end else begin
				if (lead.has_res) begin
					res.n  = NRES_ONE;
					res.r0 = '{cp: lead.cp, bad: lead.bad, fin: 1'b1};
				end
				if (lead.open) begin
					cont_d = lead.need;
					part_d = lead.payload;
				end
				if (lead.trunc) begin
					disc_d = lead.discard;
				end
			end
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q <= '0;
			part_q <= '0;
			disc_q <= '0;
		end else begin
			cont_q <= cont_d;
			part_q <= part_d;
			disc_q <= disc_d;
		end
	end

	// dropping and gathering never overlap
	a_disc_cont_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(disc_q != '0 && cont_q != '0))
		else $error("discard and continuation counts both open");

	// a pair of results always starts with a non-final replacement
	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res.n == NRES_TWO |-> (res.r0.bad && !res.r0.fin && res.r1.fin))
		else $error("malformed result pair");

	// no result while bytes are being dropped
	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && disc_q != '0) |-> res.n == NRES_NONE)
		else $error("result produced for a dropped byte");

endmodule

### sv/u8d_fifo.sv
// result queue for the utf-8 decoder: up to two writes and one read a cycle
// depends on u8d_pkg
module u8d_fifo #(
	parameter int DEPTH = u8d_pkg::FIFO_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  u8d_pkg::res_pair_t push,
	input  logic               pop,
	output logic               room,
	output logic               not_empty,
	output u8d_pkg::res_t      head
);
	import u8d_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

	res_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wr_p1, wr_p2, rd_p1;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_p1     = ptr_inc(wr_q);
	assign wr_p2     = ptr_inc(wr_p1);
	assign rd_p1     = ptr_inc(rd_q);
	assign not_empty = cnt_q != '0;
	assign room      = cnt_q <= ROOM_MAX;
	assign do_pop    = pop && not_empty;
	assign head      = mem[rd_q];

	// entry writes
	always_ff @(posedge clk) begin
		if (push.n != NRES_NONE) begin
			mem[wr_q] <= push.r0;
		end
		if (push.n == NRES_TWO) begin
			mem[wr_p1] <= push.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			unique case (push.n)
				NRES_ONE: wr_q <= wr_p1;
				NRES_TWO: wr_q <= wr_p2;
				default:  wr_q <= wr_q;
			endcase
			if (do_pop) begin
				rd_q <= rd_p1;
			end
			cnt_q <= cnt_q + CNT_W'(push.n) - CNT_W'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != NRES_NONE |-> room)
		else $error("push into result queue without room");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && push.n == NRES_NONE) |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("queue count did not follow a read");

endmodule

### test/utf8_byte_stream_decoder_tb.sv
// self-checking testbench for utf8_byte_stream_decoder: directed table, then random utf-8 strings and noise bytes
// depends on u8d_pkg for field widths, byte codes and the result type, and on utf8_byte_stream_decoder

module utf8_byte_stream_decoder_tb;
	import u8d_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1900;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 100;
	localparam int DIR_ROWS     = 26;

	// one row of stimulus; r0/r1 are only used when typed is set
	typedef struct packed {
		logic [BYTE_W-1:0]   b;
		logic [FOLLOW_W-1:0] f;
		logic                typed;
		logic [1:0]          n;
		res_t                r0;
		res_t                r1;
	} row_t;

	localparam res_t NO_RES    = '0;
	localparam res_t REPL_LAST = {REPLACEMENT_CP, 1'b1, 1'b1};
	localparam res_t REPL_MID  = {REPLACEMENT_CP, 1'b1, 1'b0};

	// directed rows: extremes, stray bytes, truncation, dropping, bad continuations
	localparam row_t DIRECTED [DIR_ROWS] = '{
		{8'h00, 2'd0, 1'b1, 2'd1, 21'h000000, 1'b0, 1'b1, NO_RES},
		{8'h7F, 2'd3, 1'b1, 2'd1, 21'h00007F, 1'b0, 1'b1, NO_RES},
		{8'h80, 2'd3, 1'b1, 2'd1, REPL_LAST, NO_RES},
		{8'hFF, 2'd0, 1'b1, 2'd1, REPL_LAST, NO_RES},
		{8'hF8, 2'd2, 1'b1, 2'd1, REPL_LAST, NO_RES},
		// two byte form
		{8'hC3, 2'd1, 1'b0, 2'd0, NO_RES, NO_RES},
		{8'hA9, 2'd0, 1'b0, 2'd0, NO_RES, NO_RES},
		// three byte form with a count that disagrees mid-sequence
		{8'hE2, 2'd2, 1'b0, 2'd0, NO_RES, NO_RES},
		{8'h82, 2'd0, 1'b0, 2'd0, NO_RES, NO_RES},
		{8'hAC, 2'd3, 1'b0, 2'd0, NO_RES, NO_RES},
		// four byte form, largest code point
		{8'hF7, 2'd3, 1'b0, 2'd0, NO_RES, NO_RES},
		{8'hBF, 2'd2, 1'b0, 2'd0, NO_RES, NO_RES},
		{8'hBF, 2'd1, 1'b0, 2'd0, NO_RES, NO_RES},
		{8'hBF, 2'd0, 1'b1, 2'd1, 21'h1FFFFF, 1'b0, 1'b1, NO_RES},
		// truncated lead, then one byte dropped
		{8'hE2, 2'd1, 1'b1, 2'd1, REPL_LAST, NO_RES},
		{8'h41, 2'd0, 1'b1, 2'd0, NO_RES, NO_RES},
		// bad continuation that is plain ascii
		{8'hC3, 2'd3, 1'b0, 2'd0, NO_RES, NO_RES},
		{8'h41, 2'd2, 1'b1, 2'd2, REPL_MID, 21'h000041, 1'b0, 1'b1},
		// bad continuation that opens a new form
		{8'hE2, 2'd3, 1'b0, 2'd0, NO_RES, NO_RES},
		{8'hC3, 2'd1, 1'b1, 2'd1, REPL_LAST, NO_RES},
		{8'hA9, 2'd0, 1'b0, 2'd0, NO_RES, NO_RES},
		// bad continuation that is itself an invalid lead
		{8'hC3, 2'd3, 1'b0, 2'd0, NO_RES, NO_RES},
		{8'hFF, 2'd0, 1'b1, 2'd2, REPL_MID, REPL_LAST},
		// truncated four byte lead, two bytes dropped whatever they hold
		{8'hF0, 2'd2, 1'b1, 2'd1, REPL_LAST, NO_RES},
		{8'h80, 2'd3, 1'b1, 2'd0, NO_RES, NO_RES},
		{8'hC3, 2'd1, 1'b1, 2'd0, NO_RES, NO_RES}
	};

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // data_byte, bytes_following, zero pad
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // code_point, zero pad
	logic                   m_tuser;         // malformed
	logic                   m_tlast;         // final_of_run

	// decoder state as predicted
	logic [COUNT_W-1:0] open_left = '0;
	logic [CP_W-1:0]    gathered  = '0;
	logic [COUNT_W-1:0] skip_left = '0;

	res_t due_results[$];
	int   errors      = 0;
	int   counted     = 0;
	int   sent_total  = 0;
	int   burst_left  = 0;
	bit   steady      = 1'b1;
	bit   hold_req    = 1'b0;

	utf8_byte_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic res_t mk(input logic [CP_W-1:0] cp, input logic bad, input logic fin);
		res_t r;
		r.cp  = cp;
		r.bad = bad;
		r.fin = fin;
		return r;
	endfunction

	// byte taken where a lead is due: ascii, a form opening, or a replacement
	function automatic int start_form(input logic [BYTE_W-1:0] b,
		input logic [FOLLOW_W-1:0] f, output res_t r);
		logic [COUNT_W-1:0] need;
		logic [BYTE_W-1:0]  pay;
		r = NO_RES;
		if (b < ASCII_LIMIT) begin
			r = mk(CP_W'(b), 1'b0, 1'b1);
			return 1;
		end
		if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			need = 2'd1;
			pay  = b & PAY2_MASK;
		end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			need = 2'd2;
			pay  = b & PAY3_MASK;
		end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
			need = 2'd3;
			pay  = b & PAY4_MASK;
		end else begin
			r = REPL_LAST;
			return 1;
		end
		// string too short for the form: drop what is left of it
		if (f < need) begin
			skip_left = f;
			r = REPL_LAST;
			return 1;
		end
		open_left = need;
		gathered  = CP_W'(pay);
		return 0;
	endfunction

	// advance the predicted state by one byte and return the results it gives
	function automatic int decode_byte(input logic [BYTE_W-1:0] b,
		input logic [FOLLOW_W-1:0] f, output res_t r0, output res_t r1);
		int n;
		r0 = NO_RES;
		r1 = NO_RES;
		if (skip_left != 0) begin
			skip_left = skip_left - 2'd1;
			return 0;
		end
		if (open_left != 0) begin
			if ((b & CONT_MASK) == CONT_CODE) begin
				gathered  = {gathered[CP_W-7:0], b[5:0]};
				open_left = open_left - 2'd1;
				if (open_left == 0) begin
					r0 = mk(gathered, 1'b0, 1'b1);
					gathered = '0;
					return 1;
				end
				return 0;
			end
			// sequence broken: replace it, then treat the byte as a lead
			open_left = '0;
			gathered  = '0;
			r0 = REPL_MID;
			n = start_form(b, f, r1);
			if (n == 0)
				r0.fin = 1'b1;
			return 1 + n;
		end
		return start_form(b, f, r0);
	endfunction

	// offer one byte, sometimes after an idle gap, wait for its transaction, then record what it should give
	task automatic send_byte(input row_t row);
		res_t r0;
		res_t r1;
		int   n;
		int   gap;
		if (sent_total % 150 == 0)
			steady = !steady;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-BYTE_W-FOLLOW_W){1'b0}}, row.f, row.b};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		burst_left--;
		sent_total++;
		if (skip_left == 0)
			counted++;
		n = decode_byte(row.b, row.f, r0, r1);
		if (row.typed) begin
			n  = row.n;
			r0 = row.r0;
			r1 = row.r1;
		end
		if (n > 0)
			due_results.push_back(r0);
		if (n > 1)
			due_results.push_back(r1);
	endtask

	// a random string of utf-8 forms, sometimes damaged, with its byte counts
	task automatic send_string();
		logic [BYTE_W-1:0] bytes[$];
		logic [31:0]       cp;
		row_t              row;
		int                nchar;
		int                kind;
		int                pos;
		int                left;
		bit                wild;
		nchar = $urandom_range(1, 6);
		for (int i = 0; i < nchar; i++) begin
			cp = $urandom();
			case ($urandom_range(0, 3))
				0: bytes.push_back({1'b0, cp[6:0]});
				1: begin
					bytes.push_back(LEAD2_CODE | {3'b0, cp[10:6]});
					bytes.push_back(CONT_CODE | {2'b0, cp[5:0]});
				end
				2: begin
					bytes.push_back(LEAD3_CODE | {4'b0, cp[15:12]});
					bytes.push_back(CONT_CODE | {2'b0, cp[11:6]});
					bytes.push_back(CONT_CODE | {2'b0, cp[5:0]});
				end
				default: begin
					bytes.push_back(LEAD4_CODE | {5'b0, cp[20:18]});
					bytes.push_back(CONT_CODE | {2'b0, cp[17:12]});
					bytes.push_back(CONT_CODE | {2'b0, cp[11:6]});
					bytes.push_back(CONT_CODE | {2'b0, cp[5:0]});
				end
			endcase
		end
		kind = $urandom_range(0, 9);
		pos  = $urandom_range(0, bytes.size() - 1);
		case (kind)
			7: bytes[pos] = BYTE_W'($urandom());
			8: begin
				// cut the last byte, so a multi-byte last form runs past the end of the string
				if (bytes.size() > 1)
					void'(bytes.pop_back());
			end
			9: bytes.insert(pos, BYTE_W'($urandom()));
			default: ;
		endcase
		wild = ($urandom_range(0, 15) == 0);
		for (int k = 0; k < bytes.size(); k++) begin
			left  = bytes.size() - 1 - k;
			row   = '0;
			row.b = bytes[k];
			row.f = wild ? FOLLOW_W'($urandom()) : ((left >= 3) ? 2'd3 : FOLLOW_W'(left));
			send_byte(row);
		end
	endtask

	// stimulus: reset, directed table, then random strings and noise
	initial begin
		row_t row;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < DIR_ROWS; i++)
			send_byte(DIRECTED[i]);
		hold_req = 1'b1;
		while (counted < RANDOM_ITEMS + DIR_ROWS) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					row   = '0;
					row.b = BYTE_W'($urandom());
					row.f = FOLLOW_W'($urandom());
					send_byte(row);
				end
			end else begin
				send_string();
			end
		end
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[utf8_byte_stream_decoder] OK");
		else
			$display("[utf8_byte_stream_decoder] ERROR");
		$finish;
	end

	// receiver: phases of steady, sparse, regular and random ready, plus one long hold
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end else begin
				mode = (cyc / 97) % 4;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) == 0);
					2: m_tready <= (cyc % 3 != 0);
					default: m_tready <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	// result check, sampled on the falling edge before the transaction edge
	always @(negedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, got cp %h malformed %b last %b",
						$time, m_tdata[CP_W-1:0], m_tuser, m_tlast);
			end else begin
				want = due_results.pop_front();
				if (m_tdata[CP_W-1:0] !== want.cp || m_tuser !== want.bad || m_tlast !== want.fin) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: mismatch, expected cp %h malformed %b last %b, got cp %h malformed %b last %b",
							$time, want.cp, want.bad, want.fin, m_tdata[CP_W-1:0], m_tuser, m_tlast);
				end
			end
		end
	end

	// overall time limit
	initial begin
		#(2 * HALF_PERIOD * 400000);
		$display("[utf8_byte_stream_decoder] ERROR");
		$finish;
	end

endmodule

### sim.f
sv/u8d_pkg.sv
sv/u8d_core.sv
sv/u8d_fifo.sv
sv/utf8_byte_stream_decoder.sv
test/utf8_byte_stream_decoder_tb.sv
